/* sv/mgpm_pkg.sv */
`default_nettype none

package mgpm_pkg;

    localparam int NUM_TRACKS   = 4;
    localparam int MAX_GAIN_DEF = 16384;
    localparam int GAIN_ONE     = 4096;
    localparam int SAMPLE_W     = 16;
    localparam int PAN_W        = 16;
    localparam int PAN_ONE      = 16384;
    localparam int PANF_W       = 15;
    localparam int FRAC_BITS    = 38;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 33;
    localparam int SAMPLE_MAX   = 32767;
    localparam int SAMPLE_MIN   = -32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRACK0      = 3'd0,
        CFG_TRACK1      = 3'd1,
        CFG_TRACK2      = 3'd2,
        CFG_TRACK3      = 3'd3,
        CFG_STEREO      = 3'd4,
        CFG_MASTER_GAIN = 3'd5
    } cfg_index_t;

endpackage

`default_nettype wire

/* sv/mgpm_in_if.sv */
`default_nettype none

interface mgpm_in_if;
    import mgpm_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_track0;
    logic signed [SAMPLE_W-1:0] sample_track1;
    logic signed [SAMPLE_W-1:0] sample_track2;
    logic signed [SAMPLE_W-1:0] sample_track3;
    logic [NUM_TRACKS-1:0]      track_present;
    logic                       is_right;
    logic                       block_end;

    modport source (
        output valid, sample_track0, sample_track1, sample_track2, sample_track3,
        output track_present, is_right, block_end,
        input  ready
    );

    modport sink (
        input  valid, sample_track0, sample_track1, sample_track2, sample_track3,
        input  track_present, is_right, block_end,
        output ready
    );

endinterface

`default_nettype wire

/* sv/mgpm_out_if.sv */
`default_nettype none

interface mgpm_out_if;
    import mgpm_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] mixed_sample;
    logic                       clipped;
    logic                       block_end_out;

    modport source (
        output valid, mixed_sample, clipped, block_end_out,
        input  ready
    );

    modport sink (
        input  valid, mixed_sample, clipped, block_end_out,
        output ready
    );

endinterface

`default_nettype wire

/* sv/multitrack_gain_pan_mixer.sv */
// four-track gain and balance-pan mixer with master gain
//
// track_in carries one sample position per beat: a sample for each slot,
// the presence mask, the left/right flag and the block end mark. mix_out
// returns one saturated int16 sample per input beat, in order.
// cfg_we/cfg_index/cfg_data write the track settings, stereo mode and master
// gain; gains and pans are clamped as they are written. Write only while idle.
//
// an accepted input beat passes through the seven-stage pipeline in order
// (gain multiply, pan multiply, track sum, magnitude, split master multiply,
// partial product add, saturate) to its output beat; throughput is one beat
// per cycle while mix_out does not stall
//
// reset empties the pipeline and loads defaults: every track muted with
// unity gain and centered pan, mono mode, unity master gain.
// when mix_out stalls each full stage holds its beat; empty stages keep
// filling, so track_in.ready drops only once the whole pipeline is full.
`default_nettype none

module multitrack_gain_pan_mixer #(
    parameter int unsigned MAX_GAIN = mgpm_pkg::MAX_GAIN_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [mgpm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mgpm_pkg::CFG_DATA_W-1:0] cfg_data,
    mgpm_in_if.sink                             track_in,
    mgpm_out_if.source                          mix_out
);
    import mgpm_pkg::*;

    localparam int GAIN_W  = $clog2(MAX_GAIN + 1);
    localparam int P1_W    = SAMPLE_W + GAIN_W + 1;
    localparam int P2_W    = P1_W + PANF_W + 1;
    localparam int ACC_W   = P2_W + $clog2(NUM_TRACKS);
    localparam int MAG_W   = ACC_W;
    localparam int LO_W    = MAG_W / 2;
    localparam int HI_W    = MAG_W - LO_W;
    localparam int PL_W    = LO_W + GAIN_W;
    localparam int PH_W    = HI_W + GAIN_W;
    localparam int PROD_W  = MAG_W + GAIN_W;
    localparam int STAGES  = 7;
    localparam int TRK_W   = $clog2(NUM_TRACKS);

    localparam logic [PROD_W-1:0] NEG_LIM = PROD_W'(-SAMPLE_MIN) << FRAC_BITS;
    localparam logic [PROD_W-1:0] POS_LIM = PROD_W'(SAMPLE_MAX) << FRAC_BITS;

    // configuration
    logic [GAIN_W-1:0]       gain_reg [NUM_TRACKS];
    logic signed [PAN_W-1:0] pan_reg  [NUM_TRACKS];
    logic [NUM_TRACKS-1:0]   mute_reg;
    logic                    stereo_reg;
    logic [GAIN_W-1:0]       master_gain_reg;

    logic [SAMPLE_W-1:0]     cfg_gain_raw;
    logic [GAIN_W-1:0]       cfg_gain;
    logic signed [PAN_W-1:0] cfg_pan_raw;
    logic signed [PAN_W-1:0] cfg_pan;

    always_comb
    begin
        cfg_gain_raw = cfg_data[SAMPLE_W-1:0];
        if (32'(cfg_gain_raw) > MAX_GAIN)
        begin
            cfg_gain = GAIN_W'(MAX_GAIN);
        end
        else
        begin
            cfg_gain = GAIN_W'(cfg_gain_raw);
        end
        cfg_pan_raw = $signed(cfg_data[2*PAN_W-1:PAN_W]);
        if (cfg_pan_raw > PAN_W'(PAN_ONE))
        begin
            cfg_pan = PAN_W'(PAN_ONE);
        end
        else if (cfg_pan_raw < -PAN_W'(PAN_ONE))
        begin
            cfg_pan = -PAN_W'(PAN_ONE);
        end
        else
        begin
            cfg_pan = cfg_pan_raw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TRACKS; i++)
            begin
                gain_reg[i] <= GAIN_W'(GAIN_ONE);
                pan_reg[i]  <= '0;
            end
            mute_reg        <= '1;
            stereo_reg      <= 1'b0;
            master_gain_reg <= GAIN_W'(GAIN_ONE);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TRACK0, CFG_TRACK1, CFG_TRACK2, CFG_TRACK3:
                begin
                    gain_reg[cfg_index[TRK_W-1:0]] <= cfg_gain;
                    pan_reg[cfg_index[TRK_W-1:0]]  <= cfg_pan;
                    mute_reg[cfg_index[TRK_W-1:0]] <= cfg_data[2*PAN_W];
                end
                CFG_STEREO:
                begin
                    stereo_reg <= cfg_data[0];
                end
                CFG_MASTER_GAIN:
                begin
                    master_gain_reg <= cfg_gain;
                end
                default:
                begin
                    stereo_reg <= stereo_reg;
                end
            endcase
        end
    end

    // pipeline control
    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic [STAGES-1:0] en;

    always_comb
    begin
        en[STAGES-1] = !vld_reg[STAGES-1] || mix_out.ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vld_next[0] = en[0] ? track_in.valid : vld_reg[0];
        for (int k = 1; k < STAGES; k++)
        begin
            vld_next[k] = en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign track_in.ready = en[0];

    // stage 1: sample times gain, pan factor
    logic signed [SAMPLE_W-1:0] samp [NUM_TRACKS];
    logic signed [P1_W-1:0]     p1_next   [NUM_TRACKS];
    logic [PANF_W-1:0]          panf_next [NUM_TRACKS];
    logic signed [P1_W-1:0]     p1_reg    [NUM_TRACKS];
    logic [PANF_W-1:0]          panf_reg  [NUM_TRACKS];
    logic signed [PAN_W:0]      pf;

    assign samp[0] = track_in.sample_track0;
    assign samp[1] = track_in.sample_track1;
    assign samp[2] = track_in.sample_track2;
    assign samp[3] = track_in.sample_track3;

    always_comb
    begin
        pf = '0;
        for (int i = 0; i < NUM_TRACKS; i++)
        begin
            if (track_in.track_present[i] && !mute_reg[i])
            begin
                p1_next[i] = P1_W'(samp[i]) * P1_W'($signed({1'b0, gain_reg[i]}));
            end
            else
            begin
                p1_next[i] = '0;
            end
            pf = (PAN_W + 1)'(PAN_ONE);
            if (stereo_reg)
            begin
                if (!track_in.is_right && pan_reg[i] > 0)
                begin
                    pf = (PAN_W + 1)'(PAN_ONE) - (PAN_W + 1)'(pan_reg[i]);
                end
                else if (track_in.is_right && pan_reg[i] < 0)
                begin
                    pf = (PAN_W + 1)'(PAN_ONE) + (PAN_W + 1)'(pan_reg[i]);
                end
            end
            panf_next[i] = pf[PANF_W-1:0];
        end
    end

    // stage 2: times pan factor
    logic signed [P2_W-1:0] p2_next [NUM_TRACKS];
    logic signed [P2_W-1:0] p2_reg  [NUM_TRACKS];

    always_comb
    begin
        for (int i = 0; i < NUM_TRACKS; i++)
        begin
            p2_next[i] = P2_W'(p1_reg[i]) * P2_W'($signed({1'b0, panf_reg[i]}));
        end
    end

    // stage 3: track sum
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] acc_reg;

    always_comb
    begin
        acc_next = '0;
        for (int i = 0; i < NUM_TRACKS; i++)
        begin
            acc_next = acc_next + ACC_W'(p2_reg[i]);
        end
    end

    // stage 4: sign and magnitude
    logic [MAG_W-1:0] mag_next;
    logic [MAG_W-1:0] mag_reg;

    assign mag_next = acc_reg[ACC_W-1] ? MAG_W'(-acc_reg) : MAG_W'(acc_reg);

    // stage 5: split master multiply
    logic [PL_W-1:0] pl_next;
    logic [PH_W-1:0] ph_next;
    logic [PL_W-1:0] pl_reg;
    logic [PH_W-1:0] ph_reg;

    assign pl_next = PL_W'(mag_reg[LO_W-1:0]) * PL_W'(master_gain_reg);
    assign ph_next = PH_W'(mag_reg[MAG_W-1:LO_W]) * PH_W'(master_gain_reg);

    // stage 6: partial product add
    logic [PROD_W-1:0] prod_next;
    logic [PROD_W-1:0] prod_reg;

    assign prod_next = PROD_W'(pl_reg) + (PROD_W'(ph_reg) << LO_W);

    // stage 7: saturate and truncate
    logic [SAMPLE_W-1:0]        q;
    logic signed [SAMPLE_W-1:0] res_next;
    logic                       clip_next;
    logic signed [SAMPLE_W-1:0] res_reg;
    logic                       clip_reg;

    logic neg_reg [3:STAGES-2];
    logic be_reg  [STAGES];

    always_comb
    begin
        q = prod_reg[FRAC_BITS +: SAMPLE_W];
        if (neg_reg[STAGES-2])
        begin
            clip_next = prod_reg > NEG_LIM;
            res_next  = clip_next ? SAMPLE_W'(SAMPLE_MIN) : $signed(-q);
        end
        else
        begin
            clip_next = prod_reg > POS_LIM;
            res_next  = clip_next ? SAMPLE_W'(SAMPLE_MAX) : $signed(q);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p1_reg    <= p1_next;
            panf_reg  <= panf_next;
            be_reg[0] <= track_in.block_end;
        end
        if (en[1])
        begin
            p2_reg    <= p2_next;
            be_reg[1] <= be_reg[0];
        end
        if (en[2])
        begin
            acc_reg   <= acc_next;
            be_reg[2] <= be_reg[1];
        end
        if (en[3])
        begin
            mag_reg    <= mag_next;
            neg_reg[3] <= acc_reg[ACC_W-1];
            be_reg[3]  <= be_reg[2];
        end
        if (en[4])
        begin
            pl_reg     <= pl_next;
            ph_reg     <= ph_next;
            neg_reg[4] <= neg_reg[3];
            be_reg[4]  <= be_reg[3];
        end
        if (en[5])
        begin
            prod_reg   <= prod_next;
            neg_reg[5] <= neg_reg[4];
            be_reg[5]  <= be_reg[4];
        end
        if (en[6])
        begin
            res_reg   <= res_next;
            clip_reg  <= clip_next;
            be_reg[6] <= be_reg[5];
        end
    end

    assign mix_out.valid         = vld_reg[STAGES-1];
    assign mix_out.mixed_sample  = res_reg;
    assign mix_out.clipped       = clip_reg;
    assign mix_out.block_end_out = be_reg[STAGES-1];

    a_clip_value: assert property (@(posedge clk) disable iff (!rst_n)
        mix_out.valid && mix_out.clipped |->
            mix_out.mixed_sample == SAMPLE_W'(SAMPLE_MAX) ||
            mix_out.mixed_sample == SAMPLE_W'(SAMPLE_MIN))
        else $error("clipped beat without a saturated sample");

    a_master_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        32'(master_gain_reg) <= MAX_GAIN)
        else $error("master gain above its limit");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        track_in.valid && track_in.ready |=> vld_reg[0])
        else $error("accepted beat missing from first stage");

endmodule

`default_nettype wire
